// ===== hdl/accel_sample_filter_bank_core_macros.svh =====
// Assertion helpers shared by the filter bank modules.
`ifndef ACCEL_SAMPLE_FILTER_BANK_CORE_MACROS_SVH
`define ACCEL_SAMPLE_FILTER_BANK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASFB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/asfb_pkg.sv =====
package asfb_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TAP_W      = 15;
    localparam int LEN_W      = 8;
    localparam int INDEX_W    = 7;
    localparam int SUM_W      = 24;
    localparam int SMOOTH_W   = 32;
    localparam int Q15_SHIFT  = 15;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int FIR_W      = 35;
    localparam int TAP_COUNT  = 6;
    localparam int HIST_DEPTH = TAP_COUNT - 1;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [TAP_W-1:0] OUTER_TAP_RST      = 15'd865;
    localparam logic [TAP_W-1:0] MIDDLE_TAP_RST     = 15'd4604;
    localparam logic [TAP_W-1:0] CENTER_TAP_RST     = 15'd10915;
    localparam logic [TAP_W-1:0] SMOOTHING_GAIN_RST = 15'd3277;
    localparam logic [LEN_W-1:0] RECORD_LENGTH_RST  = 8'd100;

    localparam logic [REG_IDX_W-1:0] REG_OUTER_TAP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIDDLE_TAP     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_TAP     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SMOOTHING_GAIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECORD_LENGTH  = 3'd4;

    localparam logic signed [MUL_A_W-1:0] Q15_ONE   = 17'sd32768;
    localparam logic signed [PROD_W-1:0]  Q15_BIAS  = 49'sd32767;
    localparam logic signed [PROD_W-1:0]  SAT16_MAX = 49'sd32767;
    localparam logic signed [PROD_W-1:0]  SAT16_MIN = -49'sd32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       restart;
    } t_in_item;

    typedef struct packed {
        logic                       valid_res;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] raw;
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] fir_out;
        logic signed [SAMPLE_W-1:0] iir_out;
        logic                       last;
    } t_out_item;

    typedef struct packed {
        logic [TAP_W-1:0] outer_tap;
        logic [TAP_W-1:0] middle_tap;
        logic [TAP_W-1:0] center_tap;
        logic [TAP_W-1:0] smoothing_gain;
        logic [LEN_W-1:0] record_length;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_OUTER,
        MUL_MIDDLE,
        MUL_CENTER,
        MUL_DECAY,
        MUL_GAIN
    } t_mul_op;

    typedef struct packed {
        logic    load;
        logic    sum_update;
        logic    mul_en;
        t_mul_op mul_op;
        logic    div_start;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        logic capturing;
        logic div_busy;
        logic out_free;
    } t_dp_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_OUTER,
        ST_MUL_MIDDLE,
        ST_MUL_CENTER,
        ST_MUL_DECAY,
        ST_MUL_GAIN,
        ST_DIV,
        ST_EMIT
    } t_ctrl_state;

    // Divide by 2^15 with the quotient truncated toward zero.
    function automatic logic signed [PROD_W-1:0] q15_trunc(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] bias;
        bias = v[PROD_W-1] ? Q15_BIAS : '0;
        return (v + bias) >>> Q15_SHIFT;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT16_MAX) begin
            r = 16'sh7fff;
        end else if (v < SAT16_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/accel_sample_filter_bank_core.sv =====
// Accelerometer filter bank: cumulative average, symmetric six-tap FIR and
// first-order IIR over a capture record of samples.
// Input channel: i_in_valid / o_in_ready carry one sample beat with a restart
// flag. Output channel: o_out_valid / i_out_ready carry one result beat per
// sample. Registers are written over the APB port (psel, penable, pwrite,
// paddr, pwdata); pready is tied high and prdata returns the addressed register.
// Samples are taken one at a time. Inside a record a sample passes the check,
// five multiply steps and the divide wait before its result is written to the
// output register: the shared multiplier makes five products, one a cycle, and
// the bit-serial divider one quotient bit per cycle over the 24-bit running sum.
// A sample outside a record skips both and goes from the check to the result.
// If the receiver stalls, the result waits in the output register while the
// next sample is already accepted and processed; the block only holds its
// finished result when the output register is still occupied.
// Reset (synchronous, active low) loads the default taps, gain and record
// length, clears the filter state and leaves the block outside any record.

module accel_sample_filter_bank_core #(
    parameter int MAX_RECORD = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  asfb_pkg::t_in_item                  i_in_data,

    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output asfb_pkg::t_out_item                 o_out_data,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [asfb_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [asfb_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [asfb_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import asfb_pkg::*;

    t_cfg                 r_cfg;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    t_dp_cmd              cmd;
    t_dp_status           status;

    // Register file. Writes complete in the access phase; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_tap      <= OUTER_TAP_RST;
            r_cfg.middle_tap     <= MIDDLE_TAP_RST;
            r_cfg.center_tap     <= CENTER_TAP_RST;
            r_cfg.smoothing_gain <= SMOOTHING_GAIN_RST;
            r_cfg.record_length  <= RECORD_LENGTH_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_OUTER_TAP:      r_cfg.outer_tap      <= pwdata[TAP_W-1:0];
                REG_MIDDLE_TAP:     r_cfg.middle_tap     <= pwdata[TAP_W-1:0];
                REG_CENTER_TAP:     r_cfg.center_tap     <= pwdata[TAP_W-1:0];
                REG_SMOOTHING_GAIN: r_cfg.smoothing_gain <= pwdata[TAP_W-1:0];
                REG_RECORD_LENGTH:  r_cfg.record_length  <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read mux; addresses past the last register read as zero.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_OUTER_TAP:      prdata = APB_DATA_W'(r_cfg.outer_tap);
            REG_MIDDLE_TAP:     prdata = APB_DATA_W'(r_cfg.middle_tap);
            REG_CENTER_TAP:     prdata = APB_DATA_W'(r_cfg.center_tap);
            REG_SMOOTHING_GAIN: prdata = APB_DATA_W'(r_cfg.smoothing_gain);
            REG_RECORD_LENGTH:  prdata = APB_DATA_W'(r_cfg.record_length);
            default:            prdata = '0;
        endcase
    end

    // The controller sequences one sample at a time through the datapath.
    asfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // The datapath holds the filter state, the shared multiplier, the
    // average divider and the output register.
    asfb_dp #(
        .MAX_RECORD (MAX_RECORD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/asfb_div.sv =====
module asfb_div #(
    parameter int DIVISOR_W = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [asfb_pkg::SUM_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]              i_divisor,
    output logic                              o_busy,
    output logic [asfb_pkg::SUM_W-1:0]        o_quotient,
    output logic                              o_neg
);
    import asfb_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;
    logic                 r_neg;

    logic [DIVISOR_W:0]   rem_sh;
    logic                 fits;
    logic [SUM_W-1:0]     magnitude;

    // Restoring division: one quotient bit per cycle, dividend bits shift out
    // of the top of the quotient register as quotient bits shift in below.
    always_comb begin
        rem_sh    = {r_rem, r_quo[SUM_W-1]};
        fits      = (rem_sh >= {1'b0, r_dvs});
        magnitude = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SUM_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= magnitude;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? DIVISOR_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;
    assign o_neg      = r_neg;

endmodule

// ===== hdl/asfb_ctrl.sv =====
`include "accel_sample_filter_bank_core_macros.svh"

module asfb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output asfb_pkg::t_dp_cmd    o_cmd,
    input  asfb_pkg::t_dp_status i_status
);
    import asfb_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.capturing ? ST_MUL_OUTER : ST_EMIT;
            end
            ST_MUL_OUTER:  n_state = ST_MUL_MIDDLE;
            ST_MUL_MIDDLE: n_state = ST_MUL_CENTER;
            ST_MUL_CENTER: n_state = ST_MUL_DECAY;
            ST_MUL_DECAY:  n_state = ST_MUL_GAIN;
            ST_MUL_GAIN:   n_state = ST_DIV;
            ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.mul_op     = MUL_OUTER;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.sum_update = 1'b1;
            end
            ST_MUL_OUTER: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_op    = MUL_OUTER;
                o_cmd.div_start = 1'b1;
            end
            ST_MUL_MIDDLE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_MIDDLE;
            end
            ST_MUL_CENTER: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_CENTER;
            end
            ST_MUL_DECAY: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_DECAY;
            end
            ST_MUL_GAIN: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_GAIN;
            end
            ST_DIV: begin
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    `ASFB_ASSERT_NEXT(a_load_goes_to_check, i_clk, i_rst_n, o_cmd.load, r_state == ST_CHECK, "accepted sample did not advance to the check step")
    `ASFB_ASSERT_SAME(a_emit_needs_room, i_clk, i_rst_n, o_cmd.emit, i_status.out_free, "result emitted while the output register was occupied")
    `ASFB_ASSERT_SAME(a_emit_after_divide, i_clk, i_rst_n, r_state == ST_EMIT, !i_status.div_busy, "result step reached while the divider was still running")

endmodule

// ===== hdl/asfb_dp.sv =====
`include "accel_sample_filter_bank_core_macros.svh"

module asfb_dp #(
    parameter int MAX_RECORD = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  asfb_pkg::t_cfg       i_cfg,
    input  asfb_pkg::t_in_item   i_in_data,
    input  asfb_pkg::t_dp_cmd    i_cmd,
    output asfb_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output asfb_pkg::t_out_item  o_out_data
);
    import asfb_pkg::*;

    localparam int PW    = (MAX_RECORD > 2) ? $clog2(MAX_RECORD) : 1;
    localparam int DVW   = PW + 1;
    localparam int CMP_W = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;

    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(1 << (SUM_W - 1));

    // Filter state.
    logic signed [SAMPLE_W-1:0] r_hist [HIST_DEPTH];
    logic signed [SUM_W-1:0]    r_sum;
    logic [PW-1:0]              r_position;
    logic                       r_capturing;
    logic signed [SMOOTH_W-1:0] r_smoothed;

    // Per-sample working registers.
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PROD_W-1:0]   r_prod;
    t_mul_op                    r_prod_op;
    logic                       r_prod_vld;
    logic signed [FIR_W-1:0]    r_fir_acc;
    logic signed [SMOOTH_W-1:0] r_decay;

    logic                       r_out_valid;
    t_out_item                  r_out;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [SAMPLE_W:0]   pair;
    logic signed [MUL_A_W-1:0]  gain_s;
    logic signed [SUM_W:0]      sum_ext;
    logic signed [SUM_W-1:0]    sum_sat;
    logic [CMP_W-1:0]           len_raw;
    logic [CMP_W-1:0]           len_eff;
    logic [CMP_W-1:0]           pos_next;
    logic                       is_last;
    logic [DVW-1:0]             divisor;
    logic                       div_busy;
    logic [SUM_W-1:0]           quotient;
    logic                       quot_neg;
    logic signed [SUM_W:0]      avg_full;
    logic                       out_free;

    // Shared multiplier operand selection.
    always_comb begin
        gain_s = $signed({2'b00, i_cfg.smoothing_gain});
        pair   = '0;
        mul_a  = '0;
        mul_b  = '0;
        case (i_cmd.mul_op)
            MUL_OUTER: begin
                pair  = (SAMPLE_W + 1)'(r_x) + (SAMPLE_W + 1)'(r_hist[4]);
                mul_a = $signed({2'b00, i_cfg.outer_tap});
                mul_b = MUL_B_W'(pair);
            end
            MUL_MIDDLE: begin
                pair  = (SAMPLE_W + 1)'(r_hist[0]) + (SAMPLE_W + 1)'(r_hist[3]);
                mul_a = $signed({2'b00, i_cfg.middle_tap});
                mul_b = MUL_B_W'(pair);
            end
            MUL_CENTER: begin
                pair  = (SAMPLE_W + 1)'(r_hist[1]) + (SAMPLE_W + 1)'(r_hist[2]);
                mul_a = $signed({2'b00, i_cfg.center_tap});
                mul_b = MUL_B_W'(pair);
            end
            MUL_DECAY: begin
                mul_a = Q15_ONE - gain_s;
                mul_b = r_smoothed;
            end
            MUL_GAIN: begin
                mul_a = gain_s;
                mul_b = MUL_B_W'(r_x);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        sum_ext = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_x);
        if (sum_ext > SUM_MAX) begin
            sum_sat = SUM_MAX[SUM_W-1:0];
        end else if (sum_ext < SUM_MIN) begin
            sum_sat = SUM_MIN[SUM_W-1:0];
        end else begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end

    // Record length is clamped to one at the bottom and MAX_RECORD at the top.
    always_comb begin
        len_raw = CMP_W'(i_cfg.record_length);
        if (len_raw == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_raw > CMP_W'(MAX_RECORD)) begin
            len_eff = CMP_W'(MAX_RECORD);
        end else begin
            len_eff = len_raw;
        end
        pos_next = CMP_W'(r_position) + CMP_W'(1);
        is_last  = (pos_next >= len_eff);
        divisor  = DVW'(r_position) + DVW'(1);
        avg_full = quot_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    end

    asfb_div #(
        .DIVISOR_W (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_quotient (quotient),
        .o_neg      (quot_neg)
    );

    // Filter state: restart clears at load, the sum moves at the check step,
    // the IIR value when the gain product lands, the rest when the result leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_sum       <= '0;
            r_position  <= '0;
            r_capturing <= 1'b0;
            r_smoothed  <= '0;
        end else begin
            if (i_cmd.load && i_in_data.restart) begin
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    r_hist[k] <= '0;
                end
                r_sum       <= '0;
                r_position  <= '0;
                r_capturing <= 1'b1;
                r_smoothed  <= '0;
            end else begin
                if (i_cmd.sum_update && r_capturing) begin
                    r_sum <= sum_sat;
                end
                if (r_prod_vld && (r_prod_op == MUL_GAIN)) begin
                    r_smoothed <= SMOOTH_W'(r_prod + PROD_W'(r_decay));
                end
                if (i_cmd.emit && r_capturing) begin
                    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                        r_hist[k] <= r_hist[k-1];
                    end
                    r_hist[0] <= r_x;
                    if (is_last) begin
                        r_capturing <= 1'b0;
                        r_position  <= '0;
                    end else begin
                        r_position <= r_position + PW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_in_data.sample;
        end
        if (i_cmd.mul_en) begin
            r_prod    <= mul_a * mul_b;
            r_prod_op <= i_cmd.mul_op;
        end
        if (r_prod_vld) begin
            case (r_prod_op) inside
                MUL_OUTER: r_fir_acc <= FIR_W'(r_prod);
                MUL_MIDDLE, MUL_CENTER: r_fir_acc <= r_fir_acc + FIR_W'(r_prod);
                MUL_DECAY: r_decay <= SMOOTH_W'(q15_trunc(r_prod));
                default: begin
                end
            endcase
        end
    end

    // Output register: a finished result waits here while the next sample
    // is already being taken in.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.raw <= r_x;
            if (r_capturing) begin
                r_out.valid_res <= 1'b1;
                r_out.index     <= INDEX_W'(r_position);
                r_out.average   <= sat16(PROD_W'(avg_full));
                r_out.fir_out   <= sat16(q15_trunc(PROD_W'(r_fir_acc)));
                r_out.iir_out   <= sat16(q15_trunc(PROD_W'(r_smoothed)));
                r_out.last      <= is_last;
            end else begin
                r_out.valid_res <= 1'b0;
                r_out.index     <= '0;
                r_out.average   <= '0;
                r_out.fir_out   <= '0;
                r_out.iir_out   <= '0;
                r_out.last      <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;
    assign o_status.capturing = r_capturing;
    assign o_status.div_busy  = div_busy;
    assign o_status.out_free  = out_free;

    `ASFB_ASSERT_SAME(a_position_in_range, i_clk, i_rst_n, r_capturing, (CMP_W'(r_position) < CMP_W'(MAX_RECORD)), "record position beyond the largest record")
    `ASFB_ASSERT_NEXT(a_last_closes_record, i_clk, i_rst_n, i_cmd.emit && r_capturing && is_last, !r_capturing && (r_position == '0), "last result did not close the record")
    `ASFB_ASSERT_NEXT(a_idle_keeps_sum, i_clk, i_rst_n, i_cmd.emit && !r_capturing, $stable(r_sum) && $stable(r_smoothed), "filter state changed outside a record")

endmodule
